### rtl/core/http_qvalue_weight_parser_assert.svh
// Assertion macros shared by the modules of the q-value weight parser.
// Each macro names one concurrent assertion, clocked on the rising edge
// and disabled while the synchronous active-low reset is applied.
`ifndef HTTP_QVALUE_WEIGHT_PARSER_ASSERT_SVH
`define HTTP_QVALUE_WEIGHT_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HQWP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HQWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hqwp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqwp_pkg
// Shared constants and the result record of the q-value weight parser.
// ----------------------------------------------------------------------------
package hqwp_pkg;

    localparam int unsigned LEN_W    = 16;
    localparam int unsigned WEIGHT_W = 10;
    localparam int unsigned ACC_W    = 14;

    // Length counters saturate at this value.
    localparam logic [LEN_W-1:0] MAX_LEN = 16'hFFFF;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 10'd1000;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Q_LO  = 8'h71;
    localparam logic [7:0] CH_Q_UP  = 8'h51;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [LEN_W-1:0]    lead_spaces;
        logic [LEN_W-1:0]    token_length;
        logic [WEIGHT_W-1:0] weight_milli;
        logic                has_params;
        logic                overflow;
    } t_result;

endpackage

### rtl/core/hqwp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqwp_core
// Per-element scan state and its one-byte update; presents the result that
// the element would give if the current byte were its last.
// ----------------------------------------------------------------------------
module hqwp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output hqwp_pkg::t_result o_res
);
    import hqwp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_TOKEN  = 3'd1,
        PH_SEARCH = 3'd2,
        PH_VALUE  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    t_phase           r_phase,     n_phase;
    logic [LEN_W-1:0] r_space_cnt, n_space_cnt;
    logic [LEN_W-1:0] r_token_pos, n_token_pos;
    logic [LEN_W-1:0] r_trim_len,  n_trim_len;
    logic             r_saw_q,     n_saw_q;
    logic [2:0]       r_digit_idx, n_digit_idx;
    logic [ACC_W-1:0] r_weight,    n_weight;
    logic             r_ovf,       n_ovf;

    logic             is_digit;
    logic [ACC_W-1:0] digit_val;
    logic [LEN_W:0]   space_inc;
    logic [LEN_W:0]   token_inc;

    // Saturating increment: MSB of the result is the overflow flag.
    function automatic logic [LEN_W:0] sat_inc(input logic [LEN_W-1:0] v);
        if (v >= MAX_LEN) begin
            sat_inc = {1'b1, MAX_LEN};
        end else begin
            sat_inc = {1'b0, v + 16'd1};
        end
    endfunction

    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit_val = is_digit ? ACC_W'(i_char - CH_ZERO) : '0;
    assign space_inc = sat_inc(r_space_cnt);
    assign token_inc = sat_inc(r_token_pos);

    always_comb begin
        n_phase     = r_phase;
        n_space_cnt = r_space_cnt;
        n_token_pos = r_token_pos;
        n_trim_len  = r_trim_len;
        n_saw_q     = r_saw_q;
        n_digit_idx = r_digit_idx;
        n_weight    = r_weight;
        n_ovf       = r_ovf;
        unique case (r_phase)
            PH_LEAD: begin
                if (i_char == CH_SPACE) begin
                    n_space_cnt = space_inc[LEN_W-1:0];
                    n_ovf       = r_ovf | space_inc[LEN_W];
                end else if (i_char == CH_SEMI) begin
                    n_phase = PH_SEARCH;
                    n_saw_q = 1'b0;
                end else begin
                    n_token_pos = 16'd1;
                    n_trim_len  = 16'd1;
                    n_phase     = PH_TOKEN;
                end
            end
            PH_TOKEN: begin
                if (i_char == CH_SEMI) begin
                    n_phase = PH_SEARCH;
                    n_saw_q = 1'b0;
                end else begin
                    n_token_pos = token_inc[LEN_W-1:0];
                    n_ovf       = r_ovf | token_inc[LEN_W];
                    if (i_char != CH_SPACE) begin
                        n_trim_len = token_inc[LEN_W-1:0];
                    end
                end
            end
            PH_SEARCH: begin
                if (r_saw_q && (i_char == CH_EQ)) begin
                    n_phase     = PH_VALUE;
                    n_digit_idx = 3'd0;
                    n_weight    = '0;
                end else begin
                    n_saw_q = (i_char == CH_Q_LO) || (i_char == CH_Q_UP);
                end
            end
            PH_VALUE: begin
                // Value reads as d[.ddd]; any mismatch ends the scan.
                unique case (r_digit_idx)
                    3'd0: begin
                        if (is_digit) begin
                            n_weight    = ACC_W'(digit_val * 14'd1000);
                            n_digit_idx = 3'd1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    3'd1: begin
                        if (i_char == CH_DOT) begin
                            n_digit_idx = 3'd2;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    3'd2: begin
                        if (is_digit) begin
                            n_weight    = r_weight + ACC_W'(digit_val * 14'd100);
                            n_digit_idx = 3'd3;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    3'd3: begin
                        if (is_digit) begin
                            n_weight    = r_weight + ACC_W'(digit_val * 14'd10);
                            n_digit_idx = 3'd4;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_weight = r_weight + digit_val;
                        n_phase  = PH_DONE;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.lead_spaces  = n_space_cnt;
        o_res.token_length = n_trim_len;
        o_res.has_params   = (n_phase >= PH_SEARCH);
        o_res.overflow     = n_ovf;
        if ((n_phase == PH_LEAD) || (n_phase == PH_TOKEN) || (n_phase == PH_SEARCH)) begin
            o_res.weight_milli = WEIGHT_FULL;
        end else if (n_weight > ACC_W'(WEIGHT_FULL)) begin
            o_res.weight_milli = WEIGHT_FULL;
        end else begin
            o_res.weight_milli = n_weight[WEIGHT_W-1:0];
        end
    end

    // The last byte of an element returns the scan to its start state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase     <= PH_LEAD;
            r_space_cnt <= '0;
            r_token_pos <= '0;
            r_trim_len  <= '0;
            r_saw_q     <= 1'b0;
            r_digit_idx <= '0;
            r_weight    <= '0;
            r_ovf       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_space_cnt <= n_space_cnt;
            r_token_pos <= n_token_pos;
            r_trim_len  <= n_trim_len;
            r_saw_q     <= n_saw_q;
            r_digit_idx <= n_digit_idx;
            r_weight    <= n_weight;
            r_ovf       <= n_ovf;
        end
    end

endmodule

### rtl/core/http_qvalue_weight_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_qvalue_weight_parser
// Parses one HTTP list element byte by byte and reports leading spaces,
// trimmed token length, parameter presence and the q weight in thousandths.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | i_in_valid/o_in_stall | i_char_in, i_is_last
//  out     | o_out_valid/i_out_stall | o_lead_spaces, o_token_length,
//          |                       | o_weight_milli, o_has_params, o_overflow
//
// One byte is taken every cycle while the input is not stalled; the scan state updates once per byte.
// An element's result is registered in the output register as its last byte
// leaves the input stage. Reset is synchronous and clears the input and output
// valid flags and the scan state. A stalled result holds the output register;
// other bytes keep flowing, and a last byte waits in the input stage.
module http_qvalue_weight_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_lead_spaces,
    output logic [15:0] o_token_length,
    output logic [9:0]  o_weight_milli,
    output logic        o_has_params,
    output logic        o_overflow
);
    import hqwp_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       out_free;
    logic       advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_char <= i_char_in;
            r_s1_last <= i_is_last;
        end
    end

    hqwp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_char  (r_s1_char),
        .i_last  (r_s1_last),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_last) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_lead_spaces  = r_out.lead_spaces;
    assign o_token_length = r_out.token_length;
    assign o_weight_milli = r_out.weight_milli;
    assign o_has_params   = r_out.has_params;
    assign o_overflow     = r_out.overflow;

`include "http_qvalue_weight_parser_assert.svh"

    `HQWP_ASSERT_NOW(a_weight_range, i_clk, i_rst_n, o_out_valid, o_weight_milli <= WEIGHT_FULL, "weight above full scale")
    `HQWP_ASSERT_NOW(a_no_params_full, i_clk, i_rst_n, o_out_valid && !o_has_params, o_weight_milli == WEIGHT_FULL, "weight not full without parameters")
    `HQWP_ASSERT_NEXT(a_last_reaches_out, i_clk, i_rst_n, r_s1_valid && r_s1_last && out_free, o_out_valid, "last byte did not produce a result")

endmodule
